// ===== design/crse_pkg.sv =====
// Shared types and constants of the Catmull-Rom segment evaluator.
// Used by the front end, the command queue, the back end and the top level.
package crse_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned ParamW    = 17;
  localparam int unsigned WinDepth  = 4;
  localparam int unsigned LoadW     = 3;
  localparam int unsigned NumLanes  = 3;
  localparam int unsigned NumSteps  = 8;
  localparam int unsigned StepW     = 4;
  localparam int unsigned TFracBits = 16;
  localparam int unsigned CoefW     = 18;
  localparam int unsigned OpndW     = 33;
  localparam int unsigned ProdW     = CoefW + OpndW;
  localparam int unsigned AccW      = 54;
  localparam int unsigned BasW      = 54;
  localparam int unsigned T2W       = 33;
  localparam int unsigned T3W       = 50;
  localparam int unsigned OutShift  = 17;

  localparam logic [ParamW-1:0] TOne = ParamW'(65536);

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_EVAL = 1'b1
  } mode_e;

  typedef struct packed {
    logic                                    is_eval;
    logic                                    incomplete;
    logic [ParamW-1:0]                       t;
    logic [NumLanes-1:0][CoordW-1:0]         pt;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SQ    = 6'b000010,
    S_CUBE  = 6'b000100,
    S_BASIS = 6'b001000,
    S_MAC   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

endpackage

// ===== design/crse_front.sv =====
// Front end: accepts input beats, clamps t and tags evaluations with the window fill state.
// Depends on crse_pkg.
module crse_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic signed [31:0]          point_z_i,
  input  logic [16:0]                 param_t_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output crse_pkg::entry_t            q_entry_o
);

  logic [crse_pkg::LoadW-1:0] loaded_d, loaded_q;
  logic                       accept;
  logic                       is_eval;
  logic                       incomplete;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign accept     = in_valid_i & q_ready_i;
  assign is_eval    = (mode_i == crse_pkg::MODE_EVAL);
  assign incomplete = (loaded_q < crse_pkg::LoadW'(crse_pkg::WinDepth));

  always_comb begin
    q_entry_o.is_eval    = is_eval;
    q_entry_o.incomplete = incomplete;
    q_entry_o.t          = (param_t_i > crse_pkg::TOne) ? crse_pkg::TOne : param_t_i;
    q_entry_o.pt[0]      = point_x_i;
    q_entry_o.pt[1]      = point_y_i;
    q_entry_o.pt[2]      = point_z_i;
  end

  always_comb begin
    loaded_d = loaded_q;
    if (accept && !is_eval && incomplete) begin
      loaded_d = loaded_q + crse_pkg::LoadW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

endmodule

// ===== design/crse_queue.sv =====
// Command queue between the front end and the back end.
// Depends on crse_pkg for the entry type.
module crse_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  crse_pkg::entry_t wr_entry_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output crse_pkg::entry_t rd_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  crse_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// ===== design/crse_back.sv =====
// Back end: holds the control point window and evaluates the segment with one multiplier
// per coordinate lane, then rounds, clamps and registers the result. Depends on crse_pkg.
module crse_back (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               rd_valid_i,
  output logic                                               rd_ready_o,
  input  crse_pkg::entry_t                                   rd_entry_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [crse_pkg::NumLanes-1:0][crse_pkg::CoordW-1:0] pos_o,
  output logic [crse_pkg::NumLanes-1:0][crse_pkg::CoordW-1:0] tan_o,
  output logic                                               incomplete_o,
  output logic                                               saturated_o
);

  localparam int unsigned NumLanes = crse_pkg::NumLanes;
  localparam int unsigned CoordW   = crse_pkg::CoordW;
  localparam int unsigned CoefW    = crse_pkg::CoefW;
  localparam int unsigned OpndW    = crse_pkg::OpndW;
  localparam int unsigned ProdW    = crse_pkg::ProdW;
  localparam int unsigned AccW     = crse_pkg::AccW;
  localparam int unsigned BasW     = crse_pkg::BasW;
  localparam int unsigned StepW    = crse_pkg::StepW;
  localparam int unsigned NumSteps = crse_pkg::NumSteps;
  localparam int unsigned TFrac    = crse_pkg::TFracBits;

  localparam logic signed [BasW-1:0] HalfP  = BasW'(64'h0000_0000_8000_0000);
  localparam logic signed [BasW-1:0] HalfD  = BasW'(64'h0000_0000_0000_8000);
  localparam logic signed [BasW-1:0] SSq    = BasW'(64'h0000_0001_0000_0000);
  localparam logic signed [BasW-1:0] SCube  = BasW'(64'h0001_0000_0000_0000);
  localparam logic signed [AccW-1:0] AccHalf = AccW'(64'h0000_0000_0001_0000);
  localparam logic signed [AccW-1:0] AccMax  = AccW'(64'h0000_0000_7FFF_FFFF);
  localparam logic signed [AccW-1:0] AccMin  = AccW'($signed(32'h8000_0000));

  crse_pkg::state_e state_d, state_q;
  logic [StepW-1:0] step_d, step_q;
  logic             out_valid_d, out_valid_q;
  logic             load_out;

  logic [crse_pkg::WinDepth-1:0][NumLanes-1:0][CoordW-1:0] win_q;

  logic [crse_pkg::ParamW-1:0] t_q;
  logic                        inc_q;
  logic [crse_pkg::T2W-1:0]    t2_q;
  logic [crse_pkg::T3W-1:0]    t3_q;

  logic signed [CoefW-1:0] coef_d [NumSteps];
  logic signed [CoefW-1:0] coef_q [NumSteps];
  logic signed [OpndW-1:0] opnd_d [NumLanes][4];
  logic signed [OpndW-1:0] opnd_q [NumLanes][4];
  logic signed [ProdW-1:0] prod_q [NumLanes];
  logic                    prod_tan_q;
  logic signed [AccW-1:0]  acc_pos_q [NumLanes];
  logic signed [AccW-1:0]  acc_tan_q [NumLanes];

  logic [NumLanes-1:0][CoordW-1:0] pos_q, tan_q, pos_r, tan_r;
  logic [NumLanes-1:0]             sat_pos, sat_tan;
  logic                            sat_q;

  function automatic logic signed [CoefW-1:0] round_p(input logic signed [BasW-1:0] h);
    logic signed [BasW-1:0] r;
    r = (h + HalfP) >>> 32;
    return r[CoefW-1:0];
  endfunction

  function automatic logic signed [CoefW-1:0] round_d(input logic signed [BasW-1:0] h);
    logic signed [BasW-1:0] r;
    r = (h + HalfD) >>> TFrac;
    return r[CoefW-1:0];
  endfunction

  function automatic logic [CoordW:0] round_clamp(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    r = (acc + AccHalf) >>> crse_pkg::OutShift;
    if (r > AccMax) begin
      return {1'b1, AccMax[CoordW-1:0]};
    end else if (r < AccMin) begin
      return {1'b1, AccMin[CoordW-1:0]};
    end
    return {1'b0, r[CoordW-1:0]};
  endfunction

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    rd_ready_o  = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      crse_pkg::S_IDLE: begin
        rd_ready_o = 1'b1;
        if (rd_valid_i && rd_entry_i.is_eval) begin
          state_d = crse_pkg::S_SQ;
        end
      end
      crse_pkg::S_SQ: begin
        state_d = crse_pkg::S_CUBE;
      end
      crse_pkg::S_CUBE: begin
        state_d = crse_pkg::S_BASIS;
      end
      crse_pkg::S_BASIS: begin
        step_d  = '0;
        state_d = crse_pkg::S_MAC;
      end
      crse_pkg::S_MAC: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(NumSteps)) begin
          state_d = crse_pkg::S_OUT;
        end
      end
      crse_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = crse_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = crse_pkg::S_IDLE;
      end
    endcase
  end

  // Basis polynomials from t, t^2 and t^3, and the per-lane operands from the window.
  always_comb begin
    logic signed [BasW-1:0] tv, t2v, t3v, ts, ts2, t2s;
    tv  = BasW'(t_q);
    t2v = BasW'(t2_q);
    t3v = BasW'(t3_q);
    ts  = tv <<< TFrac;
    ts2 = tv <<< (2 * TFrac);
    t2s = t2v <<< TFrac;
    coef_d[0] = round_p((t3v <<< 1) - 3 * t2s + SCube);
    coef_d[1] = round_p(t3v - (t2s <<< 1) + ts2);
    coef_d[2] = round_p(3 * t2s - (t3v <<< 1));
    coef_d[3] = round_p(t3v - t2s);
    coef_d[4] = round_d(6 * t2v - 6 * ts);
    coef_d[5] = round_d(3 * t2v - 4 * ts + SSq);
    coef_d[6] = round_d(6 * ts - 6 * t2v);
    coef_d[7] = round_d(3 * t2v - (ts <<< 1));
    for (int c = 0; c < NumLanes; c++) begin
      opnd_d[c][0] = OpndW'($signed(win_q[1][c])) <<< 1;
      opnd_d[c][1] = OpndW'($signed(win_q[2][c])) - OpndW'($signed(win_q[0][c]));
      opnd_d[c][2] = OpndW'($signed(win_q[2][c])) <<< 1;
      opnd_d[c][3] = OpndW'($signed(win_q[3][c])) - OpndW'($signed(win_q[1][c]));
    end
  end

  always_comb begin
    for (int c = 0; c < NumLanes; c++) begin
      {sat_pos[c], pos_r[c]} = round_clamp(acc_pos_q[c]);
      {sat_tan[c], tan_r[c]} = round_clamp(acc_tan_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crse_pkg::S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (state_q == crse_pkg::S_IDLE && rd_valid_i && !rd_entry_i.is_eval) begin
        for (int i = 0; i < crse_pkg::WinDepth - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[crse_pkg::WinDepth-1] <= rd_entry_i.pt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == crse_pkg::S_IDLE && rd_valid_i) begin
      t_q   <= rd_entry_i.t;
      inc_q <= rd_entry_i.incomplete;
    end
    if (state_q == crse_pkg::S_SQ) begin
      t2_q <= crse_pkg::T2W'(t_q) * crse_pkg::T2W'(t_q);
    end
    if (state_q == crse_pkg::S_CUBE) begin
      t3_q <= crse_pkg::T3W'(t2_q) * crse_pkg::T3W'(t_q);
    end
    if (state_q == crse_pkg::S_BASIS) begin
      coef_q <= coef_d;
      opnd_q <= opnd_d;
      for (int c = 0; c < NumLanes; c++) begin
        acc_pos_q[c] <= '0;
        acc_tan_q[c] <= '0;
      end
    end
    if (state_q == crse_pkg::S_MAC) begin
      if (step_q < StepW'(NumSteps)) begin
        prod_tan_q <= step_q[2];
        for (int c = 0; c < NumLanes; c++) begin
          prod_q[c] <= ProdW'(coef_q[step_q[2:0]]) * ProdW'(opnd_q[c][step_q[1:0]]);
        end
      end
      if (step_q != '0) begin
        for (int c = 0; c < NumLanes; c++) begin
          if (prod_tan_q) begin
            acc_tan_q[c] <= acc_tan_q[c] + AccW'(prod_q[c]);
          end else begin
            acc_pos_q[c] <= acc_pos_q[c] + AccW'(prod_q[c]);
          end
        end
      end
    end
    if (load_out) begin
      pos_q        <= pos_r;
      tan_q        <= tan_r;
      incomplete_o <= inc_q;
      sat_q        <= |{sat_pos, sat_tan};
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_o       = pos_q;
  assign tan_o       = tan_q;
  assign saturated_o = sat_q;

endmodule

// ===== design/catmull_rom_segment_eval.sv =====
// Top level of the uniform Catmull-Rom segment evaluator in 3D, signed Q16.16.
// Depends on crse_pkg, crse_front, crse_queue and crse_back.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries one beat per item.
// A beat with mode_i low pushes point_x/y/z_i into a four-point window and gives
// no result. A beat with mode_i high evaluates the segment between the two middle
// points at param_t_i (Q1.16, clamped to 1.0) and yields one result beat on the
// output channel (out_valid_o / out_ready_i): position, derivative, a flag for a
// window that has seen fewer than four pushes, and a saturation flag.
// Beats enter a command queue of QUEUE_DEPTH entries, so the input keeps taking
// beats while the back end works or while a result waits to be taken.
// The back end takes a push in its idle state. An evaluation runs through the states
// S_SQ, S_CUBE and S_BASIS, forming t^2, t^3 and the basis weights, then S_MAC,
// which runs the shared multiplier of each coordinate lane over eight products, and
// S_OUT, which rounds and clamps into the output register. The back end takes
// no new beat from the queue until that evaluation has left S_OUT.
// When the receiver stalls, the result holds in the output register, the back end
// waits with the next result, and the queue fills until in_ready_o drops.
// Reset clears the window to zero, the push count, the queue and out_valid_o.
module catmull_rom_segment_eval #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [16:0]        param_t_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] tan_x_o,
  output logic signed [31:0] tan_y_o,
  output logic signed [31:0] tan_z_o,
  output logic               window_incomplete_o,
  output logic               saturated_o
);

  logic             fq_valid, fq_ready, qb_valid, qb_ready;
  crse_pkg::entry_t fq_entry, qb_entry;
  logic [crse_pkg::NumLanes-1:0][crse_pkg::CoordW-1:0] pos, tan;

  crse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .param_t_i  (param_t_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_entry_o  (fq_entry)
  );

  crse_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_entry_i (fq_entry),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_entry_o (qb_entry)
  );

  crse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_valid_i   (qb_valid),
    .rd_ready_o   (qb_ready),
    .rd_entry_i   (qb_entry),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pos_o        (pos),
    .tan_o        (tan),
    .incomplete_o (window_incomplete_o),
    .saturated_o  (saturated_o)
  );

  assign pos_x_o = pos[0];
  assign pos_y_o = pos[1];
  assign pos_z_o = pos[2];
  assign tan_x_o = tan[0];
  assign tan_y_o = tan[1];
  assign tan_z_o = tan[2];

endmodule

// ===== design/crse_checker.sv =====
// Port-level checker for catmull_rom_segment_eval, attached by the bind at the end.
// Depends only on the top level's ports.
module crse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               mode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] pos_y_o,
  input logic signed [31:0] pos_z_o,
  input logic signed [31:0] tan_x_o,
  input logic signed [31:0] tan_y_o,
  input logic signed [31:0] tan_z_o,
  input logic               window_incomplete_o,
  input logic               saturated_o
);

  localparam logic [31:0] MaxW = 32'h7FFF_FFFF;
  localparam logic [31:0] MinW = 32'h8000_0000;

  logic [7:0] pend_d, pend_q;
  logic       full_d, full_q;
  logic       eval_beat, out_beat, any_ext;

  assign eval_beat = in_valid_i & in_ready_o & mode_i;
  assign out_beat  = out_valid_o & out_ready_i;
  assign any_ext   = (pos_x_o == MaxW) || (pos_x_o == MinW) || (pos_y_o == MaxW) ||
                     (pos_y_o == MinW) || (pos_z_o == MaxW) || (pos_z_o == MinW) ||
                     (tan_x_o == MaxW) || (tan_x_o == MinW) || (tan_y_o == MaxW) ||
                     (tan_y_o == MinW) || (tan_z_o == MaxW) || (tan_z_o == MinW);

  always_comb begin
    pend_d = pend_q + 8'(eval_beat) - 8'(out_beat);
    full_d = full_q | (out_beat & ~window_incomplete_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      full_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      full_q <= full_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(tan_z_o)
      && $stable(window_incomplete_o) && $stable(saturated_o))
    else $error("result beat changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result beat without a pending evaluation");

  a_fill_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_q |-> !window_incomplete_o)
    else $error("window reported incomplete after it was complete");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> any_ext)
    else $error("saturation flagged without a clamped coordinate");

endmodule

bind catmull_rom_segment_eval crse_checker u_crse_checker (.*);
